>>> hw/rtl/stl_pkg.sv
package stl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_OPER
    } t_mode;

    typedef enum logic [1:0] {
        PEND_EQ,
        PEND_LT,
        PEND_GT,
        PEND_BANG
    } t_pend;

    localparam logic [4:0] KIND_STRING = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_NUMBER = 5'd2;
    localparam logic [4:0] KIND_LET    = 5'd3;
    localparam logic [4:0] KIND_SEMI   = 5'd8;
    localparam logic [4:0] KIND_LPAREN = 5'd9;
    localparam logic [4:0] KIND_RPAREN = 5'd10;
    localparam logic [4:0] KIND_LBRACE = 5'd11;
    localparam logic [4:0] KIND_RBRACE = 5'd12;
    localparam logic [4:0] KIND_COMMA  = 5'd13;
    localparam logic [4:0] KIND_PLUS   = 5'd14;
    localparam logic [4:0] KIND_MINUS  = 5'd15;
    localparam logic [4:0] KIND_SLASH  = 5'd16;
    localparam logic [4:0] KIND_STAR   = 5'd17;
    localparam logic [4:0] KIND_ASSIGN = 5'd18;
    localparam logic [4:0] KIND_EQ     = 5'd19;
    localparam logic [4:0] KIND_LT     = 5'd20;
    localparam logic [4:0] KIND_LE     = 5'd21;
    localparam logic [4:0] KIND_GT     = 5'd22;
    localparam logic [4:0] KIND_GE     = 5'd23;
    localparam logic [4:0] KIND_NE     = 5'd24;
    localparam logic [4:0] KIND_END    = 5'd25;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;

    localparam int KW_COUNT   = 5;
    localparam int KW_MAX_LEN = 6;

    typedef logic [KW_MAX_LEN-1:0][7:0] t_kw_text;

    // Byte 0 of each entry holds the first character of the keyword.
    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        {24'h0, "t", "e", "l"},
        {32'h0, "n", "f"},
        {8'h0, "e", "l", "i", "h", "w"},
        {32'h0, "f", "i"},
        {"n", "r", "u", "t", "e", "r"}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd5, 3'd2, 3'd6};

endpackage

>>> hw/rtl/source_text_lexer_core.sv
// Latency: the first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte gives at most one result and the
// consumer takes it; a byte with more results holds the input until its last result
// leaves the three-entry buffer, one result per cycle while the consumer is ready.
// Reset (synchronous, active low) returns the lexer to idle at position zero and
// empties the result buffer.
module source_text_lexer_core #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_stream_end,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [4:0]               o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [POSITION_BITS-1:0] o_token_length,
    output logic [1:0]               o_error_code,
    output logic                     o_run_last
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef logic [KEYWORD_CHARS-1:0][7:0] t_kw_buf;

    typedef struct packed {
        logic [4:0]               kind;
        logic [POSITION_BITS-1:0] start;
        logic [POSITION_BITS-1:0] length;
        logic [1:0]               err;
        logic                     last;
    } t_result;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_result mk_res(input logic [4:0] kind,
                                       input logic [POSITION_BITS-1:0] start,
                                       input logic [POSITION_BITS-1:0] length,
                                       input logic [1:0] err);
        t_result r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.err    = err;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic [4:0] ident_kind(input t_kw_buf buf_in,
                                              input logic [POSITION_BITS-1:0] len);
        logic [4:0] kind;
        logic       same;
        kind = stl_pkg::KIND_IDENT;
        for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
            same = (len == POSITION_BITS'(stl_pkg::KW_LEN[k]));
            for (int j = 0; j < stl_pkg::KW_MAX_LEN; j++) begin
                if (j < int'(stl_pkg::KW_LEN[k]) && buf_in[j] != stl_pkg::KW_TEXT[k][j]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                kind = stl_pkg::KIND_LET + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] single_kind(input stl_pkg::t_pend pend);
        logic [4:0] kind;
        unique case (pend)
            stl_pkg::PEND_LT: kind = stl_pkg::KIND_LT;
            stl_pkg::PEND_GT: kind = stl_pkg::KIND_GT;
            default:          kind = stl_pkg::KIND_ASSIGN;
        endcase
        return kind;
    endfunction

    function automatic logic [4:0] pair_kind(input stl_pkg::t_pend pend);
        logic [4:0] kind;
        unique case (pend)
            stl_pkg::PEND_EQ:   kind = stl_pkg::KIND_EQ;
            stl_pkg::PEND_LT:   kind = stl_pkg::KIND_LE;
            stl_pkg::PEND_GT:   kind = stl_pkg::KIND_GE;
            stl_pkg::PEND_BANG: kind = stl_pkg::KIND_NE;
            default:            kind = stl_pkg::KIND_EQ;
        endcase
        return kind;
    endfunction

    stl_pkg::t_mode           r_mode, n_mode;
    stl_pkg::t_pend           r_pend, n_pend;
    logic [POSITION_BITS-1:0] r_cur_start, n_cur_start;
    logic [POSITION_BITS-1:0] r_cur_len, n_cur_len;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_halt, n_halt;
    t_kw_buf                  r_kw_buf, n_kw_buf;

    t_result                  r_q [3];
    t_result                  n_q [3];
    logic [1:0]               r_cnt, n_cnt;
    logic [1:0]               r_head, n_head;

    t_result                  slot [4];
    logic [3:0]               slot_vld;
    t_result                  res [3];
    logic [1:0]               res_cnt;
    logic                     used;
    logic                     halt_end;
    logic [7:0]               c;
    logic                     in_xfer;
    logic                     out_xfer;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_in_ready  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    assign o_token_kind   = r_q[r_head].kind;
    assign o_token_start  = r_q[r_head].start;
    assign o_token_length = r_q[r_head].length;
    assign o_error_code   = r_q[r_head].err;
    assign o_run_last     = r_q[r_head].last;

    always_comb begin
        c           = i_text_byte;
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_cur_start = r_cur_start;
        n_cur_len   = r_cur_len;
        n_pos       = r_pos;
        n_halt      = r_halt;
        n_kw_buf    = r_kw_buf;
        used        = 1'b0;
        halt_end    = 1'b0;
        slot_vld    = '0;
        for (int s = 0; s < 4; s++) begin
            slot[s] = '0;
        end

        if (r_halt) begin
            if (i_stream_end) begin
                n_mode      = stl_pkg::MODE_IDLE;
                n_pend      = stl_pkg::PEND_EQ;
                n_cur_start = '0;
                n_cur_len   = '0;
                n_pos       = '0;
                n_halt      = 1'b0;
            end
        end else begin
            case (r_mode)
                stl_pkg::MODE_IDENT, stl_pkg::MODE_NUMBER: begin
                    if ((r_mode == stl_pkg::MODE_IDENT && (is_alpha(c) || is_digit(c) || c == "_"))
                        || (r_mode == stl_pkg::MODE_NUMBER && is_digit(c))) begin
                        used      = 1'b1;
                        n_cur_len = sat_inc(r_cur_len);
                        if (r_mode == stl_pkg::MODE_IDENT) begin
                            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                                if (r_cur_len == POSITION_BITS'(j)) begin
                                    n_kw_buf[j] = c;
                                end
                            end
                        end
                    end else begin
                        slot_vld[0] = 1'b1;
                        slot[0] = mk_res((r_mode == stl_pkg::MODE_IDENT)
                                         ? ident_kind(r_kw_buf, r_cur_len)
                                         : stl_pkg::KIND_NUMBER,
                                         r_cur_start, r_cur_len, stl_pkg::ERR_NONE);
                        n_mode = stl_pkg::MODE_IDLE;
                    end
                end
                stl_pkg::MODE_STRING: begin
                    used = 1'b1;
                    if (c == "\"") begin
                        slot_vld[0] = 1'b1;
                        slot[0] = mk_res(stl_pkg::KIND_STRING, r_cur_start, r_cur_len,
                                         stl_pkg::ERR_NONE);
                        n_mode = stl_pkg::MODE_IDLE;
                    end else begin
                        n_cur_len = sat_inc(r_cur_len);
                    end
                end
                stl_pkg::MODE_OPER: begin
                    slot_vld[0] = 1'b1;
                    n_mode      = stl_pkg::MODE_IDLE;
                    if (c == "=") begin
                        used    = 1'b1;
                        slot[0] = mk_res(pair_kind(r_pend), r_cur_start, POSITION_BITS'(2),
                                         stl_pkg::ERR_NONE);
                    end else if (r_pend == stl_pkg::PEND_BANG) begin
                        used    = 1'b1;
                        n_halt  = 1'b1;
                        slot[0] = mk_res(5'd0, r_cur_start, '0, stl_pkg::ERR_INVALID);
                    end else begin
                        slot[0] = mk_res(single_kind(r_pend), r_cur_start, POSITION_BITS'(1),
                                         stl_pkg::ERR_NONE);
                    end
                end
                default: begin
                    n_mode = stl_pkg::MODE_IDLE;
                end
            endcase

            if (!used && !is_space(c)) begin
                if (c == "\"") begin
                    n_mode      = stl_pkg::MODE_STRING;
                    n_cur_start = sat_inc(r_pos);
                    n_cur_len   = '0;
                end else if (is_alpha(c) || is_digit(c)) begin
                    n_mode      = is_alpha(c) ? stl_pkg::MODE_IDENT : stl_pkg::MODE_NUMBER;
                    n_cur_start = r_pos;
                    n_cur_len   = POSITION_BITS'(1);
                    n_kw_buf[0] = c;
                end else begin
                    slot_vld[1] = 1'b1;
                    case (c)
                        ";": slot[1] = mk_res(stl_pkg::KIND_SEMI, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "(": slot[1] = mk_res(stl_pkg::KIND_LPAREN, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        ")": slot[1] = mk_res(stl_pkg::KIND_RPAREN, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "{": slot[1] = mk_res(stl_pkg::KIND_LBRACE, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "}": slot[1] = mk_res(stl_pkg::KIND_RBRACE, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        ",": slot[1] = mk_res(stl_pkg::KIND_COMMA, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "+": slot[1] = mk_res(stl_pkg::KIND_PLUS, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "-": slot[1] = mk_res(stl_pkg::KIND_MINUS, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "/": slot[1] = mk_res(stl_pkg::KIND_SLASH, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "*": slot[1] = mk_res(stl_pkg::KIND_STAR, r_pos, POSITION_BITS'(1),
                                              stl_pkg::ERR_NONE);
                        "=", "<", ">", "!": begin
                            slot_vld[1] = 1'b0;
                            n_mode      = stl_pkg::MODE_OPER;
                            n_cur_start = r_pos;
                            n_cur_len   = POSITION_BITS'(1);
                            case (c)
                                "=":     n_pend = stl_pkg::PEND_EQ;
                                "<":     n_pend = stl_pkg::PEND_LT;
                                ">":     n_pend = stl_pkg::PEND_GT;
                                default: n_pend = stl_pkg::PEND_BANG;
                            endcase
                        end
                        default: begin
                            slot[1] = mk_res(5'd0, r_pos, '0, stl_pkg::ERR_INVALID);
                            n_halt  = 1'b1;
                            n_mode  = stl_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end

            n_pos = sat_inc(r_pos);

            if (i_stream_end) begin
                if (!n_halt) begin
                    case (n_mode)
                        stl_pkg::MODE_IDENT, stl_pkg::MODE_NUMBER: begin
                            slot_vld[2] = 1'b1;
                            slot[2] = mk_res((n_mode == stl_pkg::MODE_IDENT)
                                             ? ident_kind(n_kw_buf, n_cur_len)
                                             : stl_pkg::KIND_NUMBER,
                                             n_cur_start, n_cur_len, stl_pkg::ERR_NONE);
                        end
                        stl_pkg::MODE_STRING: begin
                            slot_vld[2] = 1'b1;
                            halt_end    = 1'b1;
                            slot[2] = mk_res(5'd0, n_cur_start, '0, stl_pkg::ERR_UNCLOSED);
                        end
                        stl_pkg::MODE_OPER: begin
                            slot_vld[2] = 1'b1;
                            if (n_pend == stl_pkg::PEND_BANG) begin
                                halt_end = 1'b1;
                                slot[2]  = mk_res(5'd0, n_cur_start, '0, stl_pkg::ERR_INVALID);
                            end else begin
                                slot[2] = mk_res(single_kind(n_pend), n_cur_start,
                                                 POSITION_BITS'(1), stl_pkg::ERR_NONE);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!halt_end) begin
                        slot_vld[3] = 1'b1;
                        slot[3] = mk_res(stl_pkg::KIND_END, n_pos, '0, stl_pkg::ERR_NONE);
                    end
                end
                n_mode      = stl_pkg::MODE_IDLE;
                n_pend      = stl_pkg::PEND_EQ;
                n_cur_start = '0;
                n_cur_len   = '0;
                n_pos       = '0;
                n_halt      = 1'b0;
            end
        end
    end

    // At most three results are kept per byte; a fourth is dropped.
    always_comb begin
        res_cnt = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end
        for (int s = 0; s < 4; s++) begin
            if (slot_vld[s] && res_cnt != 2'd3) begin
                res[res_cnt] = slot[s];
                res_cnt      = res_cnt + 2'd1;
            end
        end
        if (res_cnt != 2'd0) begin
            res[res_cnt - 2'd1].last = 1'b1;
        end
    end

    always_comb begin
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_head = r_head;
        if (in_xfer) begin
            n_q    = res;
            n_cnt  = res_cnt;
            n_head = 2'd0;
        end else if (out_xfer) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= stl_pkg::MODE_IDLE;
            r_pend      <= stl_pkg::PEND_EQ;
            r_cur_start <= '0;
            r_cur_len   <= '0;
            r_pos       <= '0;
            r_halt      <= 1'b0;
            r_cnt       <= 2'd0;
            r_head      <= 2'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
            if (in_xfer) begin
                r_mode      <= n_mode;
                r_pend      <= n_pend;
                r_cur_start <= n_cur_start;
                r_cur_len   <= n_cur_len;
                r_pos       <= n_pos;
                r_halt      <= n_halt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kw_buf <= n_kw_buf;
        end
        r_q <= n_q;
    end

endmodule

>>> hw/rtl/stl_checker.sv
module stl_checker #(
    parameter int POSITION_BITS = 16
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic [7:0]               i_text_byte,
    input logic                     i_stream_end,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [4:0]               o_token_kind,
    input logic [POSITION_BITS-1:0] o_token_start,
    input logic [POSITION_BITS-1:0] o_token_length,
    input logic [1:0]               o_error_code,
    input logic                     o_run_last
);

    // The result buffer is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_token_kind) && $stable(o_token_start)
            && $stable(o_token_length) && $stable(o_error_code) && $stable(o_run_last))
        else $error("stalled result changed");

    // A byte's results follow one another without a gap.
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_last |=> o_out_valid)
        else $error("gap inside a burst of results");

    // No new byte is taken while more than the final result of a byte is pending.
    a_burst_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> !o_in_ready)
        else $error("input taken in the middle of a burst");

    // Error results carry kind code zero and no length.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != stl_pkg::ERR_NONE |->
            o_token_kind == stl_pkg::KIND_STRING && o_token_length == '0)
        else $error("malformed error result");

endmodule

bind source_text_lexer_core stl_checker #(.POSITION_BITS(POSITION_BITS)) u_stl_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [4:0] KIND_NONE = 5'd0;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last;
    } t_token;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         typed;
        int         cnt;
        t_token     tok [3];
    } t_text_row;

    localparam t_token NO_TOK = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_stream_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic [1:0]  o_error_code;
    logic        o_run_last;

    source_text_lexer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_stream_end   (i_stream_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_error_code   (o_error_code),
        .o_run_last     (o_run_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    stl_pkg::t_mode lex_mode;
    stl_pkg::t_pend lex_pend;
    logic [15:0]    lex_start;
    logic [15:0]    lex_len;
    logic [15:0]    lex_pos;
    logic [7:0]     lex_kw [stl_pkg::KW_MAX_LEN];
    logic           lex_halt;
    t_token         lex_out [3];
    int             lex_n;

    t_token      pending_tokens [$];
    int          mismatches;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    logic [7:0]  src_text [$];
    t_text_row   dir_rows [$];
    t_token      no_toks [3];

    bit          drv_typed;
    int          drv_cnt;
    t_token      drv_tok [3];

    string kw_names [5]  = '{"let", "fn", "while", "if", "return"};
    string pair_ops [4]  = '{"==", "<=", ">=", "!="};
    string word_chars    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string punct_chars   = ";(){},+-/*";
    string single_ops    = "=<>";
    string bad_chars     = "#$%&@[]^`|~?:.'\\";

    function automatic void put_char(input logic [7:0] b);
        src_text = {src_text, b};
    endfunction

    function automatic void put_token(input t_token t);
        pending_tokens = {pending_tokens, t};
    endfunction

    function automatic logic [15:0] sat_next(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic t_token tk(input logic [4:0] kind, input logic [15:0] start,
                                  input logic [15:0] len, input logic [1:0] err,
                                  input logic last);
        return '{kind, start, len, err, last};
    endfunction

    function void emit_token(input logic [4:0] kind, input logic [15:0] start,
                             input logic [15:0] len, input logic [1:0] err);
        if (lex_n < 3) begin
            lex_out[lex_n] = tk(kind, start, len, err, 1'b0);
            lex_n++;
        end
    endfunction

    function void lex_error(input logic [15:0] pos, input logic [1:0] code);
        emit_token(KIND_NONE, pos, 16'd0, code);
        lex_halt = 1'b1;
        lex_mode = stl_pkg::MODE_IDLE;
    endfunction

    function logic [4:0] word_kind();
        bit same;
        for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
            if (lex_len == 16'(stl_pkg::KW_LEN[k]) &&
                stl_pkg::KW_LEN[k] <= stl_pkg::KW_MAX_LEN) begin
                same = 1'b1;
                for (int j = 0; j < stl_pkg::KW_LEN[k]; j++)
                    if (lex_kw[j] != stl_pkg::KW_TEXT[k][j])
                        same = 1'b0;
                if (same)
                    return stl_pkg::KIND_LET + 5'(k);
            end
        end
        return stl_pkg::KIND_IDENT;
    endfunction

    function void flush_word();
        emit_token((lex_mode == stl_pkg::MODE_IDENT) ? word_kind() : stl_pkg::KIND_NUMBER,
                   lex_start, lex_len, stl_pkg::ERR_NONE);
        lex_mode = stl_pkg::MODE_IDLE;
    endfunction

    function void flush_operator();
        case (lex_pend)
            stl_pkg::PEND_EQ: emit_token(stl_pkg::KIND_ASSIGN, lex_start, 16'd1,
                                         stl_pkg::ERR_NONE);
            stl_pkg::PEND_LT: emit_token(stl_pkg::KIND_LT, lex_start, 16'd1,
                                         stl_pkg::ERR_NONE);
            stl_pkg::PEND_GT: emit_token(stl_pkg::KIND_GT, lex_start, 16'd1,
                                         stl_pkg::ERR_NONE);
            default: lex_error(lex_start, stl_pkg::ERR_INVALID);
        endcase
        lex_mode = stl_pkg::MODE_IDLE;
    endfunction

    function void open_token(input logic [7:0] c, input logic [15:0] p);
        if (is_blank(c))
            return;
        if (c == "\"") begin
            lex_mode = stl_pkg::MODE_STRING;
            lex_start = sat_next(p);
            lex_len = 16'd0;
            return;
        end
        if (is_letter(c) || is_digit(c)) begin
            lex_mode = is_letter(c) ? stl_pkg::MODE_IDENT : stl_pkg::MODE_NUMBER;
            lex_start = p;
            lex_len = 16'd1;
            lex_kw[0] = c;
            return;
        end
        case (c)
            ";": emit_token(stl_pkg::KIND_SEMI, p, 16'd1, stl_pkg::ERR_NONE);
            "(": emit_token(stl_pkg::KIND_LPAREN, p, 16'd1, stl_pkg::ERR_NONE);
            ")": emit_token(stl_pkg::KIND_RPAREN, p, 16'd1, stl_pkg::ERR_NONE);
            "{": emit_token(stl_pkg::KIND_LBRACE, p, 16'd1, stl_pkg::ERR_NONE);
            "}": emit_token(stl_pkg::KIND_RBRACE, p, 16'd1, stl_pkg::ERR_NONE);
            ",": emit_token(stl_pkg::KIND_COMMA, p, 16'd1, stl_pkg::ERR_NONE);
            "+": emit_token(stl_pkg::KIND_PLUS, p, 16'd1, stl_pkg::ERR_NONE);
            "-": emit_token(stl_pkg::KIND_MINUS, p, 16'd1, stl_pkg::ERR_NONE);
            "/": emit_token(stl_pkg::KIND_SLASH, p, 16'd1, stl_pkg::ERR_NONE);
            "*": emit_token(stl_pkg::KIND_STAR, p, 16'd1, stl_pkg::ERR_NONE);
            "=", "<", ">", "!": begin
                lex_pend = (c == "=") ? stl_pkg::PEND_EQ : (c == "<") ? stl_pkg::PEND_LT :
                           (c == ">") ? stl_pkg::PEND_GT : stl_pkg::PEND_BANG;
                lex_mode = stl_pkg::MODE_OPER;
                lex_start = p;
                lex_len = 16'd1;
            end
            default: lex_error(p, stl_pkg::ERR_INVALID);
        endcase
    endfunction

    function void grow_token(input logic [7:0] c);
        if (lex_mode == stl_pkg::MODE_IDENT && lex_len < stl_pkg::KW_MAX_LEN)
            lex_kw[lex_len] = c;
        lex_len = sat_next(lex_len);
    endfunction

    function void lex_clear();
        lex_mode = stl_pkg::MODE_IDLE;
        lex_pend = stl_pkg::PEND_EQ;
        lex_start = 16'd0;
        lex_len = 16'd0;
        lex_pos = 16'd0;
        lex_halt = 1'b0;
    endfunction

    function void lex_byte(input logic [7:0] c, input logic fin);
        logic [15:0] p;
        bit          used;
        lex_n = 0;
        if (lex_halt) begin
            if (fin)
                lex_clear();
            return;
        end
        p = lex_pos;
        used = 1'b0;
        case (lex_mode)
            stl_pkg::MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == "_") begin
                    grow_token(c);
                    used = 1'b1;
                end else begin
                    flush_word();
                end
            end
            stl_pkg::MODE_NUMBER: begin
                if (is_digit(c)) begin
                    grow_token(c);
                    used = 1'b1;
                end else begin
                    flush_word();
                end
            end
            stl_pkg::MODE_STRING: begin
                if (c == "\"") begin
                    emit_token(stl_pkg::KIND_STRING, lex_start, lex_len, stl_pkg::ERR_NONE);
                    lex_mode = stl_pkg::MODE_IDLE;
                end else begin
                    grow_token(c);
                end
                used = 1'b1;
            end
            stl_pkg::MODE_OPER: begin
                if (c == "=") begin
                    emit_token((lex_pend == stl_pkg::PEND_EQ) ? stl_pkg::KIND_EQ :
                               (lex_pend == stl_pkg::PEND_LT) ? stl_pkg::KIND_LE :
                               (lex_pend == stl_pkg::PEND_GT) ? stl_pkg::KIND_GE :
                               stl_pkg::KIND_NE,
                               lex_start, 16'd2, stl_pkg::ERR_NONE);
                    lex_mode = stl_pkg::MODE_IDLE;
                    used = 1'b1;
                end else begin
                    flush_operator();
                    used = lex_halt;
                end
            end
            default: lex_mode = stl_pkg::MODE_IDLE;
        endcase
        if (!used)
            open_token(c, p);
        lex_pos = sat_next(p);
        if (fin) begin
            if (!lex_halt) begin
                if (lex_mode == stl_pkg::MODE_IDENT || lex_mode == stl_pkg::MODE_NUMBER)
                    flush_word();
                else if (lex_mode == stl_pkg::MODE_STRING)
                    lex_error(lex_start, stl_pkg::ERR_UNCLOSED);
                else if (lex_mode == stl_pkg::MODE_OPER)
                    flush_operator();
                if (!lex_halt)
                    emit_token(stl_pkg::KIND_END, lex_pos, 16'd0, stl_pkg::ERR_NONE);
            end
            lex_clear();
        end
        if (lex_n > 0)
            lex_out[lex_n-1].last = 1'b1;
    endfunction

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_token();
        t_token want;
        if (pending_tokens.size() == 0) begin
            report($sformatf("transfer of kind %0d with no token pending", o_token_kind));
            return;
        end
        want = pending_tokens.pop_front();
        if (o_token_kind !== want.kind)
            report($sformatf("token_kind %0d, expected %0d", o_token_kind, want.kind));
        if (o_token_start !== want.start)
            report($sformatf("token_start %0d, expected %0d", o_token_start, want.start));
        if (o_token_length !== want.len)
            report($sformatf("token_length %0d, expected %0d", o_token_length, want.len));
        if (o_error_code !== want.err)
            report($sformatf("error_code %0d, expected %0d", o_error_code, want.err));
        if (o_run_last !== want.last)
            report($sformatf("run_last %0d, expected %0d", o_run_last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_token();
            if (i_in_valid && o_in_ready) begin
                lex_byte(i_text_byte, i_stream_end);
                if (drv_typed) begin
                    for (int i = 0; i < drv_cnt; i++)
                        put_token(drv_tok[i]);
                end else begin
                    for (int i = 0; i < lex_n; i++)
                        put_token(lex_out[i]);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);

    task automatic send_byte(input logic [7:0] ch, input logic fin, input bit typed,
                             input int cnt, input t_token toks [3]);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_text_byte <= ch;
        i_stream_end <= fin;
        drv_typed = typed;
        drv_cnt = cnt;
        drv_tok = toks;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_text();
        for (int i = 0; i < src_text.size(); i++)
            send_byte(src_text[i], i == src_text.size() - 1, 1'b0, 0, no_toks);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void add_row(input logic [7:0] ch, input logic fin, input bit typed,
                                    input int cnt, input t_token t0, input t_token t1,
                                    input t_token t2);
        t_text_row r;
        r.ch = ch;
        r.fin = fin;
        r.typed = typed;
        r.cnt = cnt;
        r.tok[0] = t0;
        r.tok[1] = t1;
        r.tok[2] = t2;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_free(input logic [7:0] ch, input logic fin);
        add_row(ch, fin, 1'b0, 0, NO_TOK, NO_TOK, NO_TOK);
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? 8'h20 : 8'(8 + k);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic void add_token();
        int         n;
        logic [7:0] b;
        case ($urandom_range(7))
            0: begin
                add_text(kw_names[$urandom_range(4)]);
                if ($urandom_range(3) == 0)
                    put_char(word_chars[$urandom_range(62)]);
            end
            1: begin
                put_char(word_chars[$urandom_range(51)]);
                n = $urandom_range(7);
                repeat (n) put_char(word_chars[$urandom_range(62)]);
            end
            2: begin
                n = $urandom_range(1, 5);
                repeat (n) put_char(8'("0") + 8'($urandom_range(9)));
            end
            3: begin
                put_char("\"");
                n = $urandom_range(6);
                repeat (n) begin
                    b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(32, 126));
                    if (b == "\"")
                        b = "_";
                    put_char(b);
                end
                put_char("\"");
            end
            4: put_char(punct_chars[$urandom_range(9)]);
            5: add_text(pair_ops[$urandom_range(3)]);
            6: begin
                put_char(single_ops[$urandom_range(2)]);
                if ($urandom_range(1))
                    put_char(blank_char());
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) put_char(blank_char());
            end
        endcase
    endfunction

    function automatic void gen_stream();
        int form;
        int n;
        form = $urandom_range(99);
        src_text.delete();
        if (form < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) put_char(8'($urandom_range(255)));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                add_token();
                if ($urandom_range(1))
                    put_char(blank_char());
            end
            if (form < 24) begin
                case ($urandom_range(2))
                    0: add_text("! ");
                    1: begin
                        if ($urandom_range(1))
                            put_char(8'($urandom_range(128, 255)));
                        else
                            put_char(bad_chars[$urandom_range(bad_chars.len() - 1)]);
                    end
                    default: begin
                        put_char("\"");
                        repeat ($urandom_range(3)) put_char("z");
                    end
                endcase
                if ($urandom_range(1))
                    add_token();
            end
        end
    endfunction

    initial begin
        int sent;
        mismatches = 0;
        for (int i = 0; i < stl_pkg::KW_MAX_LEN; i++)
            lex_kw[i] = 8'h00;
        lex_clear();
        no_toks = '{NO_TOK, NO_TOK, NO_TOK};
        drv_typed = 1'b0;
        drv_cnt = 0;
        drv_tok = no_toks;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_text_byte = 8'h00;
        i_stream_end = 1'b0;
        i_out_ready = 1'b0;
        snd_idle_pct = 25;
        rcv_idle_pct = 49;

        // An error in the middle of a stream, then bytes that are ignored up to the end.
        add_row(";", 1'b0, 1'b1, 1,
                tk(stl_pkg::KIND_SEMI, 16'd0, 16'd1, stl_pkg::ERR_NONE, 1'b1),
                NO_TOK, NO_TOK);
        add_free("l", 1'b0);
        add_free("e", 1'b0);
        add_free("t", 1'b0);
        add_free(" ", 1'b0);
        add_free("!", 1'b0);
        add_free("=", 1'b0);
        add_free("<", 1'b0);
        add_free("A", 1'b0);
        add_free(8'hFF, 1'b0);
        add_row("x", 1'b1, 1'b1, 0, NO_TOK, NO_TOK, NO_TOK);
        add_row("=", 1'b1, 1'b1, 2,
                tk(stl_pkg::KIND_ASSIGN, 16'd0, 16'd1, stl_pkg::ERR_NONE, 1'b0),
                tk(stl_pkg::KIND_END, 16'd1, 16'd0, stl_pkg::ERR_NONE, 1'b1), NO_TOK);
        add_row("!", 1'b1, 1'b1, 1,
                tk(KIND_NONE, 16'd0, 16'd0, stl_pkg::ERR_INVALID, 1'b1),
                NO_TOK, NO_TOK);
        add_row("\"", 1'b1, 1'b1, 1,
                tk(KIND_NONE, 16'd1, 16'd0, stl_pkg::ERR_UNCLOSED, 1'b1),
                NO_TOK, NO_TOK);
        add_row(8'h00, 1'b0, 1'b1, 1,
                tk(KIND_NONE, 16'd0, 16'd0, stl_pkg::ERR_INVALID, 1'b1),
                NO_TOK, NO_TOK);
        add_row("9", 1'b1, 1'b1, 0, NO_TOK, NO_TOK, NO_TOK);
        add_free("7", 1'b0);
        add_free("x", 1'b1);
        add_free("\"", 1'b0);
        add_free("q", 1'b0);
        add_free("\"", 1'b0);
        add_free(">", 1'b1);
        add_row(8'h80, 1'b1, 1'b1, 1,
                tk(KIND_NONE, 16'd0, 16'd0, stl_pkg::ERR_INVALID, 1'b1),
                NO_TOK, NO_TOK);
        add_row(8'h0D, 1'b0, 1'b1, 0, NO_TOK, NO_TOK, NO_TOK);
        add_row(",", 1'b1, 1'b1, 2,
                tk(stl_pkg::KIND_COMMA, 16'd1, 16'd1, stl_pkg::ERR_NONE, 1'b0),
                tk(stl_pkg::KIND_END, 16'd2, 16'd0, stl_pkg::ERR_NONE, 1'b1), NO_TOK);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].cnt, dir_rows[i].tok);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 49 : 0;
            rcv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 25 : 0;
            drain();
            sent = 0;
            while (sent < 72) begin
                gen_stream();
                send_text();
                sent += src_text.size();
                if ($urandom_range(19) == 0)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("source_text_lexer_core: match");
        else
            $display("source_text_lexer_core: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("source_text_lexer_core: mismatch");
        $finish;
    end

endmodule
